>>> sv/kic_pkg.sv
// Package: key codes, status codes and controller states for the keypad calculator.
`timescale 1ns / 1ps
package kic_pkg;
  localparam logic [7:0] KEY_CLEAR = 8'h63;
  localparam logic [7:0] KEY_EVAL  = 8'h3D;
  localparam logic [7:0] KEY_PLUS  = 8'h2B;
  localparam logic [7:0] KEY_MINUS = 8'h2D;
  localparam logic [7:0] KEY_MUL   = 8'h2A;
  localparam logic [7:0] KEY_DIV   = 8'h2F;
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;
  localparam logic [3:0] RADIX     = 4'd10;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_MATH   = 2'd2;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_MUL  = 2'd1,
    PEND_DIV  = 2'd2
  } pend_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CHK_FIRST,
    S_RD_LAST,
    S_CHK_LAST,
    S_RD_KEY,
    S_KEY,
    S_TERM,
    S_MUL,
    S_DIV,
    S_OP,
    S_FINISH,
    S_OUT
  } state_t;

  function automatic logic is_digit(input logic [7:0] k);
    return (k >= KEY_ZERO) && (k <= KEY_NINE);
  endfunction

  function automatic logic is_op(input logic [7:0] k);
    return (k == KEY_PLUS) || (k == KEY_MINUS) || (k == KEY_MUL) || (k == KEY_DIV);
  endfunction
endpackage

>>> sv/keypad_infix_calculator.sv
// Top level: keypad calculator with key buffer memory and sequential evaluator.
`timescale 1ns / 1ps
// Keypad infix calculator.
// Input channel: key (8-bit ASCII) with valid/stall. Digits and + - * / are
// appended to a key memory of MAX_KEYS entries (extra keys dropped), 'c'
// empties it, '=' evaluates and emits one word on the output channel (value,
// status); other keys are dropped. An '=' walks the memory one entry per step
// (S_RD_KEY, then S_KEY) through a synchronous-read RAM with separate write
// and read ports, with the first/last entries read up front for the syntax
// checks. Each * adds an S_MUL step; each / runs a bit-serial restoring
// divider over the 32 quotient bits.
// Multiplication by 10 for digit entry is done with shifts and adds.
// in_stall is high while an evaluation runs and while the result word waits
// at the output; a stalled result holds value and status stable.
// Reset clears the key count and the controller; memory contents are not
// cleared (entries past the count are never used).
module keypad_infix_calculator #(
  parameter int MAX_KEYS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [1:0]         status
);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  logic [7:0]    mem [MAX_KEYS];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [CW-1:0] count;

  kic_pkg::state_t state, state_next;

  logic [CW-1:0] idx, idx_next;
  logic [31:0]   num, num_next;
  logic          neg, neg_next;
  logic [31:0]   sum, sum_next;
  logic [31:0]   grp, grp_next;
  kic_pkg::pend_t pend, pend_next;
  logic          merr, merr_next;
  logic [7:0]    prev, prev_next;
  logic [7:0]    cur, cur_next;
  logic          first_bad, first_bad_next;
  logic          at_end, at_end_next;
  logic [31:0]   term, term_next;
  logic [31:0]   rem, rem_next;
  logic [31:0]   quo, quo_next;
  logic [31:0]   dvs, dvs_next;
  logic [5:0]    dcnt, dcnt_next;
  logic          qneg, qneg_next;
  logic signed [31:0] value_next;
  logic [1:0]    status_next;

  logic          in_acc;
  logic          is_store;
  logic [32:0]   rem_sh;
  logic [32:0]   rem_sub;

  assign in_stall = (state != kic_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_store = kic_pkg::is_digit(key) || kic_pkg::is_op(key);
  assign mem_we   = in_acc && is_store && (count < CW'(MAX_KEYS));
  assign out_valid = (state == kic_pkg::S_OUT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= key;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc) begin
      if (key == kic_pkg::KEY_CLEAR) begin
        count <= '0;
      end else if (mem_we) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kic_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    idx <= idx_next;   num <= num_next;   neg <= neg_next;
    sum <= sum_next;   grp <= grp_next;   pend <= pend_next;
    merr <= merr_next; prev <= prev_next; cur <= cur_next;
    first_bad <= first_bad_next; at_end <= at_end_next;
    term <= term_next; rem <= rem_next;   quo <= quo_next;
    dvs <= dvs_next;   dcnt <= dcnt_next; qneg <= qneg_next;
    value <= value_next; status <= status_next;
  end

  assign rem_sh  = {rem, quo[31]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_comb begin
    state_next = state;
    idx_next = idx; num_next = num; neg_next = neg; sum_next = sum;
    grp_next = grp; pend_next = pend; merr_next = merr; prev_next = prev;
    cur_next = cur; first_bad_next = first_bad; at_end_next = at_end;
    term_next = term; rem_next = rem; quo_next = quo; dvs_next = dvs;
    dcnt_next = dcnt; qneg_next = qneg;
    value_next = value; status_next = status;
    raddr = idx[AW-1:0];
    unique case (state)
      kic_pkg::S_IDLE: begin
        raddr = '0;
        if (in_acc && key == kic_pkg::KEY_EVAL) begin
          if (count == '0) begin
            value_next = '0;
            status_next = kic_pkg::ST_SYNTAX;
            state_next = kic_pkg::S_OUT;
          end else begin
            state_next = kic_pkg::S_RD_FIRST;
          end
        end
      end
      kic_pkg::S_RD_FIRST: begin
        raddr = '0;
        state_next = kic_pkg::S_CHK_FIRST;
      end
      kic_pkg::S_CHK_FIRST: begin
        raddr = AW'(count - CW'(1));
        first_bad_next = (rdata == kic_pkg::KEY_MUL) || (rdata == kic_pkg::KEY_DIV);
        state_next = kic_pkg::S_RD_LAST;
      end
      kic_pkg::S_RD_LAST: begin
        raddr = AW'(count - CW'(1));
        state_next = kic_pkg::S_CHK_LAST;
      end
      kic_pkg::S_CHK_LAST: begin
        if (first_bad || kic_pkg::is_op(rdata)) begin
          value_next = '0;
          status_next = kic_pkg::ST_SYNTAX;
          state_next = kic_pkg::S_OUT;
        end else begin
          idx_next = '0; num_next = '0; neg_next = 1'b0; sum_next = '0;
          grp_next = '0; pend_next = kic_pkg::PEND_NONE; merr_next = 1'b0;
          prev_next = kic_pkg::KEY_ZERO;
          state_next = kic_pkg::S_RD_KEY;
        end
      end
      kic_pkg::S_RD_KEY: begin
        if (idx == count) begin
          term_next = neg ? (32'd0 - num) : num;
          at_end_next = 1'b1;
          state_next = kic_pkg::S_TERM;
        end else begin
          state_next = kic_pkg::S_KEY;
        end
      end
      kic_pkg::S_KEY: begin
        cur_next = rdata;
        prev_next = rdata;
        idx_next = idx + CW'(1);
        state_next = kic_pkg::S_RD_KEY;
        if (kic_pkg::is_digit(rdata)) begin
          num_next = (num << 3) + (num << 1) + 32'(rdata - kic_pkg::KEY_ZERO);
        end else if (idx != '0 && !kic_pkg::is_digit(prev)) begin
          if (rdata == kic_pkg::KEY_MINUS) neg_next = !neg;
        end else begin
          term_next = neg ? (32'd0 - num) : num;
          at_end_next = 1'b0;
          state_next = kic_pkg::S_TERM;
        end
      end
      kic_pkg::S_TERM: begin
        raddr = idx[AW-1:0];
        unique case (pend)
          kic_pkg::PEND_MUL: state_next = kic_pkg::S_MUL;
          kic_pkg::PEND_DIV: begin
            if (term == '0) begin
              grp_next = '0;
              merr_next = 1'b1;
              state_next = at_end ? kic_pkg::S_FINISH : kic_pkg::S_OP;
            end else begin
              rem_next = '0;
              quo_next = grp[31] ? (32'd0 - grp) : grp;
              dvs_next = term[31] ? (32'd0 - term) : term;
              qneg_next = grp[31] ^ term[31];
              dcnt_next = '0;
              state_next = kic_pkg::S_DIV;
            end
          end
          default: begin
            grp_next = term;
            state_next = at_end ? kic_pkg::S_FINISH : kic_pkg::S_OP;
          end
        endcase
      end
      kic_pkg::S_MUL: begin
        grp_next = grp * term;
        state_next = at_end ? kic_pkg::S_FINISH : kic_pkg::S_OP;
      end
      kic_pkg::S_DIV: begin
        if (dcnt == 6'd32) begin
          grp_next = qneg ? (32'd0 - quo) : quo;
          state_next = at_end ? kic_pkg::S_FINISH : kic_pkg::S_OP;
        end else begin
          if (!rem_sub[32]) begin
            rem_next = rem_sub[31:0];
            quo_next = {quo[30:0], 1'b1};
          end else begin
            rem_next = rem_sh[31:0];
            quo_next = {quo[30:0], 1'b0};
          end
          dcnt_next = dcnt + 6'd1;
        end
      end
      kic_pkg::S_OP: begin
        num_next = '0;
        neg_next = 1'b0;
        state_next = kic_pkg::S_RD_KEY;
        case (cur) inside
          kic_pkg::KEY_PLUS, kic_pkg::KEY_MINUS: begin
            sum_next = sum + grp;
            grp_next = '0;
            pend_next = kic_pkg::PEND_NONE;
            neg_next = (cur == kic_pkg::KEY_MINUS);
          end
          kic_pkg::KEY_MUL: pend_next = kic_pkg::PEND_MUL;
          default:          pend_next = kic_pkg::PEND_DIV;
        endcase
      end
      kic_pkg::S_FINISH: begin
        value_next = sum + grp;
        status_next = merr ? kic_pkg::ST_MATH : kic_pkg::ST_OK;
        state_next = kic_pkg::S_OUT;
      end
      kic_pkg::S_OUT: begin
        if (!out_stall) state_next = kic_pkg::S_IDLE;
      end
      default: state_next = kic_pkg::S_IDLE;
    endcase
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEYS)) else $error("key count past depth");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("result word changed under stall");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status code");
  a_syntax_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == kic_pkg::ST_SYNTAX |-> value == '0)
    else $error("syntax error with nonzero value");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == kic_pkg::S_KEY |-> idx < count) else $error("walk past count");
endmodule
